// ----- sv/assert_macros.svh -----
// assertion macros used by the checker file
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent, checked on every rising clock edge outside reset
`define RPMC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
      else $error("implication check failed");

// expression must never hold outside reset
`define RPMC_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`endif

// ----- sv/rpmc_pkg.sv -----
// shared types, widths, mode codes and sepia constants of the pixel mode converter
// no dependencies; used by every module of the block by scoped names
package rpmc_pkg;

   // sample and field widths
   localparam int FIELD_W     = 16;
   localparam int SAMPLE_BITS = 16;
   localparam logic [FIELD_W-1:0] SAMPLE_MASK =
      FIELD_W'((17'd1 << SAMPLE_BITS) - 17'd1);
   localparam int NUM_CHAN    = 3;

   // configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] REG_CONV_MODE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CHANNEL_SEL = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_INPUT_MAX   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_GRAY_MAX    = 2'd3;

   // conversion modes
   localparam logic [2:0] MODE_BITMAP  = 3'd0;
   localparam logic [2:0] MODE_GRAY    = 3'd1;
   localparam logic [2:0] MODE_ISOLATE = 3'd2;
   localparam logic [2:0] MODE_REMOVE  = 3'd3;
   localparam logic [2:0] MODE_SEPIA   = 3'd4;

   // reset values
   localparam logic [FIELD_W-1:0] INPUT_MAX_RST = 16'd255;
   localparam logic [FIELD_W-1:0] GRAY_MAX_RST  = 16'd255;

   // arithmetic widths
   localparam int SUM_W       = FIELD_W + 2;          // r+g+b
   localparam int COEF_W      = 10;
   localparam int PROD_W      = FIELD_W + COEF_W;     // sample times coefficient
   localparam int SEPIA_SUM_W = PROD_W + 1;           // three products, < 2^27
   localparam int NUM_W       = SUM_W + FIELD_W;      // (r+g+b) * gray_max
   localparam int DEN_W       = FIELD_W + 2;          // 3 * input_max

   // sepia matrix, coefficients scaled by 1000, rows red/green/blue out
   localparam logic [COEF_W-1:0] SEPIA_COEF [NUM_CHAN][NUM_CHAN] = '{
      '{10'd393, 10'd769, 10'd189},
      '{10'd349, 10'd686, 10'd168},
      '{10'd272, 10'd534, 10'd131}
   };

   // divide by 1000 as multiply by ceil(2^37/1000), exact for sums below 2^27
   localparam int RECIP_W     = 28;
   localparam int SEPIA_SHIFT = 37;
   localparam logic [RECIP_W-1:0] SEPIA_RECIP = 28'd137438954;
   localparam int SCALED_W    = SEPIA_SUM_W + RECIP_W;
   localparam int SEPIA_Q_W   = SCALED_W - SEPIA_SHIFT;

   // gray divider: two quotient bits per stage after an overflow check stage
   localparam int QUO_BITS     = FIELD_W;
   localparam int DIV_PER_STG  = 2;
   localparam int DIV_STEPS    = QUO_BITS / DIV_PER_STG;
   localparam int DIV_LAT      = DIV_STEPS + 1;

   // pipeline latencies
   localparam int FRONT_LAT = 2;
   localparam int COLOR_LAT = 2;
   localparam int COLOR_DLY = DIV_LAT - COLOR_LAT;
   localparam int TOTAL_LAT = FRONT_LAT + DIV_LAT + 1;

   // configuration snapshot
   typedef struct packed {
      logic [2:0]         conv_mode;
      logic [1:0]         channel_sel;
      logic [FIELD_W-1:0] input_max;
      logic [FIELD_W-1:0] gray_max;
   } cfg_type;

   // front-end beat handed to the divider and color paths
   typedef struct packed {
      logic                                   valid;
      logic [NUM_CHAN-1:0][FIELD_W-1:0]       px;
      logic [NUM_CHAN-1:0][SEPIA_SUM_W-1:0]   sepia_sum;
      logic [NUM_W-1:0]                       gray_num;
      logic                                   bitmap;
   } front_type;

endpackage

// ----- sv/rgb_pixel_mode_converter_unit.sv -----
// an accepted pixel passes the front, divider and output stages before its rsp_strobe beat
// throughput: one pixel per clock outside reset; the depth is set by the nine-stage gray divider
//   (overflow check, then two quotient bits a stage) plus two front and one output stage
// the receiver cannot stall; every result is shown for exactly one cycle
// synchronous reset clears all valid bits and loads the register reset values;
//   busy is high only while reset is held
module rgb_pixel_mode_converter_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [rpmc_pkg::FIELD_W-1:0]        req_in_red,
   input  logic [rpmc_pkg::FIELD_W-1:0]        req_in_green,
   input  logic [rpmc_pkg::FIELD_W-1:0]        req_in_blue,
   output logic                                rsp_strobe,
   output logic [rpmc_pkg::FIELD_W-1:0]        rsp_out_red,
   output logic [rpmc_pkg::FIELD_W-1:0]        rsp_out_green,
   output logic [rpmc_pkg::FIELD_W-1:0]        rsp_out_blue,
   output logic [rpmc_pkg::FIELD_W-1:0]        rsp_out_level,
   input  logic                                csr_write_en,
   input  logic [rpmc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rpmc_pkg::FIELD_W-1:0]        csr_wdata
);

   rpmc_pkg::cfg_type cfg_ff, cfg_in;
   rpmc_pkg::front_type front;
   logic accept;
   logic [rpmc_pkg::DEN_W-1:0] den;
   logic div_valid, div_ovf;
   logic [rpmc_pkg::QUO_BITS-1:0] div_quo;
   logic [rpmc_pkg::NUM_CHAN-1:0][rpmc_pkg::FIELD_W-1:0] color;
   logic [rpmc_pkg::COLOR_DLY-1:0][rpmc_pkg::NUM_CHAN-1:0][rpmc_pkg::FIELD_W-1:0]
      color_dly_ff;
   logic [rpmc_pkg::DIV_LAT-1:0] bitmap_dly_ff;
   logic strobe_ff;
   logic [rpmc_pkg::NUM_CHAN-1:0][rpmc_pkg::FIELD_W-1:0] out_color_ff;
   logic [rpmc_pkg::FIELD_W-1:0] level_ff, level_in;

   assign busy   = reset;
   assign accept = start && !busy;

   // configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            rpmc_pkg::REG_CONV_MODE:   cfg_in.conv_mode   = csr_wdata[2:0];
            rpmc_pkg::REG_CHANNEL_SEL: cfg_in.channel_sel = csr_wdata[1:0];
            rpmc_pkg::REG_INPUT_MAX:   cfg_in.input_max   = csr_wdata;
            rpmc_pkg::REG_GRAY_MAX:    cfg_in.gray_max    = csr_wdata;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.conv_mode   <= rpmc_pkg::MODE_BITMAP;
         cfg_ff.channel_sel <= '0;
         cfg_ff.input_max   <= rpmc_pkg::INPUT_MAX_RST;
         cfg_ff.gray_max    <= rpmc_pkg::GRAY_MAX_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front stages
   rpmc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .in_px    ({req_in_blue, req_in_green, req_in_red}),
      .cfg      (cfg_ff),
      .front    (front)
   );

   // divisor 3 * input_max
   assign den = (rpmc_pkg::DEN_W'(cfg_ff.input_max) << 1)
              + rpmc_pkg::DEN_W'(cfg_ff.input_max);

   rpmc_gray_div u_gray_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front.valid),
      .num       (front.gray_num),
      .den       (den),
      .out_valid (div_valid),
      .quo       (div_quo),
      .ovf       (div_ovf)
   );

   rpmc_color u_color (
      .clock (clock),
      .front (front),
      .cfg   (cfg_ff),
      .color (color)
   );

   // delay lines that line color and bitmap up with the divider output
   always_ff @(posedge clock) begin
      color_dly_ff[0]  <= color;
      bitmap_dly_ff[0] <= front.bitmap;
      for (int d = 1; d < rpmc_pkg::COLOR_DLY; d++) begin
         color_dly_ff[d] <= color_dly_ff[d-1];
      end
      for (int d = 1; d < rpmc_pkg::DIV_LAT; d++) begin
         bitmap_dly_ff[d] <= bitmap_dly_ff[d-1];
      end
   end

   // level select: saturated gray quotient or bitmap bit, zero in the other modes
   always_comb begin
      case (cfg_ff.conv_mode)
         rpmc_pkg::MODE_BITMAP: begin
            level_in = rpmc_pkg::FIELD_W'(bitmap_dly_ff[rpmc_pkg::DIV_LAT-1]);
         end
         rpmc_pkg::MODE_GRAY: begin
            level_in = (div_ovf || (div_quo > cfg_ff.gray_max)) ? cfg_ff.gray_max
                     : div_quo;
         end
         default: begin
            level_in = '0;
         end
      endcase
   end

   // output beat
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      out_color_ff <= color_dly_ff[rpmc_pkg::COLOR_DLY-1];
      level_ff     <= level_in;
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_out_red   = out_color_ff[0];
   assign rsp_out_green = out_color_ff[1];
   assign rsp_out_blue  = out_color_ff[2];
   assign rsp_out_level = level_ff;

endmodule

// ----- sv/rpmc_front.sv -----
// front end: sample masking, channel sum, sepia products and sums, gray numerator, bitmap bit
// depends on rpmc_pkg
module rpmc_front (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          in_valid,
   input  logic [rpmc_pkg::NUM_CHAN-1:0][rpmc_pkg::FIELD_W-1:0] in_px,
   input  rpmc_pkg::cfg_type                             cfg,
   output rpmc_pkg::front_type                           front
);

   // stage one registers
   logic s1_valid_ff, s1_valid_in;
   logic [rpmc_pkg::NUM_CHAN-1:0][rpmc_pkg::FIELD_W-1:0] s1_px_ff, s1_px_in;
   logic [rpmc_pkg::SUM_W-1:0] s1_sum_ff, s1_sum_in;
   logic [rpmc_pkg::NUM_CHAN-1:0][rpmc_pkg::NUM_CHAN-1:0][rpmc_pkg::PROD_W-1:0]
      s1_prod_ff, s1_prod_in;

   // stage two registers
   rpmc_pkg::front_type s2_ff, s2_in;
   logic [rpmc_pkg::SUM_W-1:0] thresh;

   // stage one: mask samples, sum channels, sepia products
   always_comb begin
      s1_valid_in = in_valid;
      for (int k = 0; k < rpmc_pkg::NUM_CHAN; k++) begin
         s1_px_in[k] = in_px[k] & rpmc_pkg::SAMPLE_MASK;
      end
      s1_sum_in = rpmc_pkg::SUM_W'(s1_px_in[0]) + rpmc_pkg::SUM_W'(s1_px_in[1])
                + rpmc_pkg::SUM_W'(s1_px_in[2]);
      for (int i = 0; i < rpmc_pkg::NUM_CHAN; i++) begin
         for (int k = 0; k < rpmc_pkg::NUM_CHAN; k++) begin
            s1_prod_in[i][k] = rpmc_pkg::PROD_W'(s1_px_in[k])
                             * rpmc_pkg::PROD_W'(rpmc_pkg::SEPIA_COEF[i][k]);
         end
      end
   end

   // bitmap threshold: floor(sum/3) < h is the same as sum < 3h
   assign thresh = (rpmc_pkg::SUM_W'(cfg.input_max[rpmc_pkg::FIELD_W-1:1]) << 1)
                 + rpmc_pkg::SUM_W'(cfg.input_max[rpmc_pkg::FIELD_W-1:1]);

   // stage two: sepia sums, gray numerator, bitmap bit
   always_comb begin
      s2_in.valid = s1_valid_ff;
      s2_in.px    = s1_px_ff;
      for (int i = 0; i < rpmc_pkg::NUM_CHAN; i++) begin
         s2_in.sepia_sum[i] = rpmc_pkg::SEPIA_SUM_W'(s1_prod_ff[i][0])
                            + rpmc_pkg::SEPIA_SUM_W'(s1_prod_ff[i][1])
                            + rpmc_pkg::SEPIA_SUM_W'(s1_prod_ff[i][2]);
      end
      s2_in.gray_num = rpmc_pkg::NUM_W'(s1_sum_ff) * rpmc_pkg::NUM_W'(cfg.gray_max);
      s2_in.bitmap   = (s1_sum_ff < thresh);
   end

   // stage registers; only the valid bits see reset
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_ff.valid <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_ff.valid <= s2_in.valid;
      end
      s1_px_ff        <= s1_px_in;
      s1_sum_ff       <= s1_sum_in;
      s1_prod_ff      <= s1_prod_in;
      s2_ff.px        <= s2_in.px;
      s2_ff.sepia_sum <= s2_in.sepia_sum;
      s2_ff.gray_num  <= s2_in.gray_num;
      s2_ff.bitmap    <= s2_in.bitmap;
   end

   assign front = s2_ff;

endmodule

// ----- sv/rpmc_gray_div.sv -----
// pipelined restoring divider for the gray level: overflow stage, then two bits a stage
// depends on rpmc_pkg
module rpmc_gray_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  logic [rpmc_pkg::NUM_W-1:0]      num,
   input  logic [rpmc_pkg::DEN_W-1:0]      den,
   output logic                            out_valid,
   output logic [rpmc_pkg::QUO_BITS-1:0]   quo,
   output logic                            ovf
);

   logic [rpmc_pkg::DIV_LAT-1:0] valid_ff, valid_in;
   logic [rpmc_pkg::DIV_LAT-1:0] ovf_ff, ovf_in;
   logic [rpmc_pkg::DIV_LAT-1:0][rpmc_pkg::NUM_W-1:0]    rem_ff, rem_in;
   logic [rpmc_pkg::DIV_LAT-1:0][rpmc_pkg::QUO_BITS-1:0] quo_ff, quo_in;

   // stage zero flags quotients that do not fit, including a zero divisor
   always_comb begin
      logic [rpmc_pkg::NUM_W-1:0]    rem_v;
      logic [rpmc_pkg::QUO_BITS-1:0] quo_v;
      logic [rpmc_pkg::NUM_W-1:0]    sub_v;
      valid_in[0] = in_valid;
      ovf_in[0]   = (num >= {den, rpmc_pkg::QUO_BITS'(0)});
      rem_in[0]   = num;
      quo_in[0]   = '0;
      // each later stage resolves two quotient bits, high bits first
      for (int j = 1; j < rpmc_pkg::DIV_LAT; j++) begin
         rem_v = rem_ff[j-1];
         quo_v = quo_ff[j-1];
         for (int s = 0; s < rpmc_pkg::DIV_PER_STG; s++) begin
            sub_v = rpmc_pkg::NUM_W'(den)
                  << (rpmc_pkg::QUO_BITS - 1 - (j - 1) * rpmc_pkg::DIV_PER_STG - s);
            if (rem_v >= sub_v) begin
               rem_v = rem_v - sub_v;
               quo_v = quo_v | (rpmc_pkg::QUO_BITS'(1)
                  << (rpmc_pkg::QUO_BITS - 1 - (j - 1) * rpmc_pkg::DIV_PER_STG - s));
            end
         end
         valid_in[j] = valid_ff[j-1];
         ovf_in[j]   = ovf_ff[j-1];
         rem_in[j]   = rem_v;
         quo_in[j]   = quo_v;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      ovf_ff <= ovf_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign out_valid = valid_ff[rpmc_pkg::DIV_LAT-1];
   assign quo       = quo_ff[rpmc_pkg::DIV_LAT-1];
   assign ovf       = ovf_ff[rpmc_pkg::DIV_LAT-1];

endmodule

// ----- sv/rpmc_color.sv -----
// color path: sepia divide by 1000 via reciprocal, saturation, channel isolate/remove
// depends on rpmc_pkg
module rpmc_color (
   input  logic                                                 clock,
   input  rpmc_pkg::front_type                                  front,
   input  rpmc_pkg::cfg_type                                    cfg,
   output logic [rpmc_pkg::NUM_CHAN-1:0][rpmc_pkg::FIELD_W-1:0] color
);

   logic [rpmc_pkg::NUM_CHAN-1:0][rpmc_pkg::SCALED_W-1:0] scaled_ff, scaled_in;
   logic [rpmc_pkg::NUM_CHAN-1:0][rpmc_pkg::FIELD_W-1:0]  px_ff;
   logic [rpmc_pkg::NUM_CHAN-1:0][rpmc_pkg::FIELD_W-1:0]  color_ff, color_in;

   // stage a: reciprocal multiply
   always_comb begin
      for (int i = 0; i < rpmc_pkg::NUM_CHAN; i++) begin
         scaled_in[i] = rpmc_pkg::SCALED_W'(front.sepia_sum[i])
                      * rpmc_pkg::SCALED_W'(rpmc_pkg::SEPIA_RECIP);
      end
   end

   // stage b: quotient, saturate at input max, select by mode
   always_comb begin
      logic [rpmc_pkg::SEPIA_Q_W-1:0] q_v;
      logic [rpmc_pkg::FIELD_W-1:0]   sat_v;
      for (int k = 0; k < rpmc_pkg::NUM_CHAN; k++) begin
         q_v   = scaled_ff[k][rpmc_pkg::SCALED_W-1:rpmc_pkg::SEPIA_SHIFT];
         sat_v = (q_v > rpmc_pkg::SEPIA_Q_W'(cfg.input_max)) ? cfg.input_max
               : q_v[rpmc_pkg::FIELD_W-1:0];
         case (cfg.conv_mode)
            rpmc_pkg::MODE_ISOLATE: begin
               color_in[k] = (cfg.channel_sel == 2'(k)) ? px_ff[k] : '0;
            end
            rpmc_pkg::MODE_REMOVE: begin
               color_in[k] = (cfg.channel_sel == 2'(k)) ? '0 : px_ff[k];
            end
            rpmc_pkg::MODE_SEPIA: begin
               color_in[k] = sat_v & rpmc_pkg::SAMPLE_MASK;
            end
            default: begin
               color_in[k] = '0;
            end
         endcase
      end
   end

   // payload registers; alignment with the divider comes from the delay lines of the top level
   always_ff @(posedge clock) begin
      scaled_ff <= scaled_in;
      px_ff     <= front.px;
      color_ff  <= color_in;
   end

   assign color = color_ff;

endmodule

// ----- sv/rpmc_checker.sv -----
// port-level checks on beat timing and result field usage of the converter
// depends on rpmc_pkg and assert_macros.svh; bound to the top level below
`include "assert_macros.svh"

module rpmc_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic                         rsp_strobe,
   input logic [rpmc_pkg::FIELD_W-1:0] rsp_out_red,
   input logic [rpmc_pkg::FIELD_W-1:0] rsp_out_green,
   input logic [rpmc_pkg::FIELD_W-1:0] rsp_out_blue,
   input logic [rpmc_pkg::FIELD_W-1:0] rsp_out_level
);

   // every accepted pixel yields a result beat after the fixed latency
   `RPMC_ASSERT_IMPLY(a_beat_follows_accept, clock, reset, start && !busy, ##(rpmc_pkg::TOTAL_LAT) rsp_strobe)

   // no result beat without a pixel accepted at the matching edge
   `RPMC_ASSERT_IMPLY(a_beat_has_source, clock, reset, rsp_strobe, $past(start && !busy, rpmc_pkg::TOTAL_LAT))

   // level and color fields are never both in use
   `RPMC_ASSERT_IMPLY(a_level_or_color, clock, reset, rsp_strobe, (rsp_out_level == '0) || ((rsp_out_red == '0) && (rsp_out_green == '0) && (rsp_out_blue == '0)))

   // reset flushes the pipeline
   `RPMC_ASSERT_NEVER(a_no_beat_after_reset, clock, reset, $past(reset) && rsp_strobe)

endmodule

bind rgb_pixel_mode_converter_unit rpmc_checker u_rpmc_checker (.*);

// ----- test/rgb_pixel_mode_converter_unit_tb.sv -----
// self-checking testbench for the rgb pixel mode converter: directed cases, then random traffic
// depends on rpmc_pkg and rgb_pixel_mode_converter_unit; an in-bench predictor checks every beat
`timescale 1ns / 100ps

module rgb_pixel_mode_converter_unit_tb;
   import rpmc_pkg::*;

   // channel selector codes and spare mode codes
   localparam logic [1:0] CHAN_RED   = 2'd0;
   localparam logic [1:0] CHAN_GREEN = 2'd1;
   localparam logic [1:0] CHAN_BLUE  = 2'd2;
   localparam logic [1:0] CHAN_NONE  = 2'd3;
   localparam logic [2:0] MODE_SPARE_LO = 3'd5;
   localparam logic [2:0] MODE_SPARE_HI = 3'd7;

   // timing
   localparam int RESULT_LATENCY = 12;
   localparam int DRAIN_CYCLES   = RESULT_LATENCY + 4;
   localparam int STALL_LIMIT    = 20 * RESULT_LATENCY;
   localparam int RUN_LIMIT_NS   = 2_000_000;
   localparam int PRINT_LIMIT    = 40;

   typedef struct packed {
      logic [FIELD_W-1:0] red;
      logic [FIELD_W-1:0] green;
      logic [FIELD_W-1:0] blue;
      logic [FIELD_W-1:0] level;
   } pixel_out_t;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [FIELD_W-1:0]   req_in_red = '0;
   logic [FIELD_W-1:0]   req_in_green = '0;
   logic [FIELD_W-1:0]   req_in_blue = '0;
   logic                 rsp_strobe;
   logic [FIELD_W-1:0]   rsp_out_red;
   logic [FIELD_W-1:0]   rsp_out_green;
   logic [FIELD_W-1:0]   rsp_out_blue;
   logic [FIELD_W-1:0]   rsp_out_level;
   logic                 csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [FIELD_W-1:0]   csr_wdata = '0;

   cfg_type    shadow_cfg;
   pixel_out_t pending_conversions[$];
   pixel_out_t want;
   int         error_count = 0;
   int         pixels_sent = 0;
   int         results_checked = 0;
   int         settings_applied = 0;
   int         sender_idle_pct = 0;

   rgb_pixel_mode_converter_unit dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_in_red    (req_in_red),
      .req_in_green  (req_in_green),
      .req_in_blue   (req_in_blue),
      .rsp_strobe    (rsp_strobe),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue),
      .rsp_out_level (rsp_out_level),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   // 12 ns clock
   initial begin
      forever #6 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #(RUN_LIMIT_NS);
      $display("** rgb_pixel_mode_converter_unit: FAILED **");
      $finish;
   end

   task automatic report_mismatch(string msg);
      if (error_count < PRINT_LIMIT)
         $display("MISMATCH at %0t ns: %s", $time, msg);
      error_count++;
   endtask

   // one sepia row: weighted sum scaled by 1000, truncated, clipped at the input maximum
   function automatic logic [FIELD_W-1:0] sepia_tone(int unsigned kr, int unsigned kg,
         int unsigned kb, logic [FIELD_W-1:0] r, logic [FIELD_W-1:0] g,
         logic [FIELD_W-1:0] b, logic [FIELD_W-1:0] limit);
      logic [63:0] acc;
      acc = (64'(kr) * r + 64'(kg) * g + 64'(kb) * b) / 1000;
      return (acc > limit) ? limit : acc[FIELD_W-1:0];
   endfunction

   // expected result of one pixel under the given register settings
   function automatic pixel_out_t predict_conversion(cfg_type c, logic [FIELD_W-1:0] r,
         logic [FIELD_W-1:0] g, logic [FIELD_W-1:0] b);
      pixel_out_t  o;
      logic [63:0] total;
      logic [63:0] quot;
      o = '0;
      total = 64'(r) + 64'(g) + 64'(b);
      case (c.conv_mode)
         MODE_BITMAP: begin
            o.level = ((total / 3) < (64'(c.input_max) / 2)) ? 16'd1 : 16'd0;
         end
         MODE_GRAY: begin
            if (c.input_max == '0) begin
               o.level = c.gray_max;
            end else begin
               quot = (total * c.gray_max) / (3 * 64'(c.input_max));
               o.level = (quot > c.gray_max) ? c.gray_max : quot[FIELD_W-1:0];
            end
         end
         MODE_ISOLATE: begin
            case (c.channel_sel)
               CHAN_RED:   o.red = r;
               CHAN_GREEN: o.green = g;
               CHAN_BLUE:  o.blue = b;
               default: ;
            endcase
         end
         MODE_REMOVE: begin
            o.red = r;
            o.green = g;
            o.blue = b;
            case (c.channel_sel)
               CHAN_RED:   o.red = '0;
               CHAN_GREEN: o.green = '0;
               CHAN_BLUE:  o.blue = '0;
               default: ;
            endcase
         end
         MODE_SEPIA: begin
            o.red   = sepia_tone(393, 769, 189, r, g, b, c.input_max);
            o.green = sepia_tone(349, 686, 168, r, g, b, c.input_max);
            o.blue  = sepia_tone(272, 534, 131, r, g, b, c.input_max);
         end
         default: ;
      endcase
      return o;
   endfunction

   // stop sending and wait until every expected beat is back
   task automatic settle();
      int waited;
      start <= 1'b0;
      waited = 0;
      while (pending_conversions.size() != 0 && waited < STALL_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_conversions.size() != 0) begin
         report_mismatch($sformatf("%0d expected beats never arrived",
            pending_conversions.size()));
         pending_conversions.delete();
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // write all four registers while idle; spare upper bits of the narrow ones are random
   task automatic configure(logic [2:0] mode, logic [1:0] sel, logic [FIELD_W-1:0] imax,
         logic [FIELD_W-1:0] gmax);
      logic [FIELD_W-1:0] vals[4];
      settle();
      vals[REG_CONV_MODE]   = {13'($urandom), mode};
      vals[REG_CHANNEL_SEL] = {14'($urandom), sel};
      vals[REG_INPUT_MAX]   = imax;
      vals[REG_GRAY_MAX]    = gmax;
      for (int i = 0; i < 4; i++) begin
         csr_write_en <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
         case (CSR_IDX_W'(i))
            REG_CONV_MODE:   shadow_cfg.conv_mode = vals[i][2:0];
            REG_CHANNEL_SEL: shadow_cfg.channel_sel = vals[i][1:0];
            REG_INPUT_MAX:   shadow_cfg.input_max = vals[i];
            REG_GRAY_MAX:    shadow_cfg.gray_max = vals[i];
            default: ;
         endcase
      end
      csr_write_en <= 1'b0;
      settings_applied++;
   endtask

   // send one pixel beat, with random idle cycles ahead of it
   task automatic send_pixel(logic [FIELD_W-1:0] r, logic [FIELD_W-1:0] g,
         logic [FIELD_W-1:0] b);
      while ($urandom_range(99, 0) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_in_red <= r;
      req_in_green <= g;
      req_in_blue <= b;
      do @(posedge clock); while (busy !== 1'b0);
      pending_conversions.push_back(predict_conversion(shadow_cfg, r, g, b));
      pixels_sent++;
   endtask

   // register value: extremes often, otherwise anything
   function automatic logic [FIELD_W-1:0] pick_limit();
      case ($urandom_range(7, 0))
         0: return '0;
         1: return 16'd1;
         2: return 16'd255;
         3: return 16'hFFFF;
         4: return 16'd1023;
         default: return 16'($urandom);
      endcase
   endfunction

   // sample value: mostly within the input maximum, sometimes above it
   function automatic logic [FIELD_W-1:0] pick_sample(logic [FIELD_W-1:0] limit);
      case ($urandom_range(9, 0))
         6: return limit;
         7: return '0;
         8: return 16'hFFFF;
         9: return 16'($urandom);
         default: return 16'($urandom_range(limit, 0));
      endcase
   endfunction

   // bitmap threshold around half the input maximum, and a zero maximum
   task automatic test_bitmap();
      configure(MODE_BITMAP, CHAN_RED, 16'd255, 16'd255);
      send_pixel(16'd0, 16'd0, 16'd0);
      send_pixel(16'd255, 16'd255, 16'd255);
      send_pixel(16'd126, 16'd127, 16'd127);
      send_pixel(16'd127, 16'd127, 16'd127);
      send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
      configure(MODE_BITMAP, CHAN_RED, 16'd0, 16'd255);
      send_pixel(16'd0, 16'd0, 16'd0);
   endtask

   // gray levels, clipping above the input maximum, zero input maximum
   task automatic test_grayscale();
      configure(MODE_GRAY, CHAN_RED, 16'd255, 16'd255);
      send_pixel(16'd255, 16'd255, 16'd255);
      send_pixel(16'd1, 16'd2, 16'd3);
      send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
      configure(MODE_GRAY, CHAN_GREEN, 16'd0, 16'd1000);
      send_pixel(16'd10, 16'd20, 16'd30);
      configure(MODE_GRAY, CHAN_BLUE, 16'hFFFF, 16'hFFFF);
      send_pixel(16'hFFFF, 16'd0, 16'h8000);
   endtask

   // isolate and remove with every selector, the unused one included
   task automatic test_channel_modes();
      for (int sel = 0; sel < 4; sel++) begin
         configure(MODE_ISOLATE, 2'(sel), 16'hFFFF, 16'd255);
         send_pixel(16'hFFFF, 16'h5A5A, 16'h0001);
         configure(MODE_REMOVE, 2'(sel), 16'hFFFF, 16'd255);
         send_pixel(16'h0001, 16'hA5A5, 16'hFFFF);
      end
   endtask

   // sepia at full scale, mid range and clipped at a small maximum
   task automatic test_sepia();
      configure(MODE_SEPIA, CHAN_RED, 16'hFFFF, 16'd255);
      send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_pixel(16'd100, 16'd200, 16'd50);
      configure(MODE_SEPIA, CHAN_RED, 16'd255, 16'd255);
      send_pixel(16'd255, 16'd255, 16'd255);
   endtask

   // spare mode codes give all-zero results
   task automatic test_spare_modes();
      for (int m = MODE_SPARE_LO; m <= MODE_SPARE_HI; m++) begin
         configure(3'(m), CHAN_NONE, 16'hFFFF, 16'hFFFF);
         send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
      end
   endtask

   // random settings, each followed by a burst of random pixels
   task automatic test_random_traffic(int idle_pct, int budget);
      int          sent;
      int          burst;
      logic [2:0]  mode;
      sender_idle_pct = idle_pct;
      sent = 0;
      while (sent < budget) begin
         if ($urandom_range(99, 0) < 90)
            mode = 3'($urandom_range(MODE_SEPIA, MODE_BITMAP));
         else
            mode = 3'($urandom_range(MODE_SPARE_HI, MODE_SPARE_LO));
         configure(mode, 2'($urandom_range(3, 0)), pick_limit(), pick_limit());
         burst = $urandom_range(50, 10);
         repeat (burst) begin
            send_pixel(pick_sample(shadow_cfg.input_max), pick_sample(shadow_cfg.input_max),
               pick_sample(shadow_cfg.input_max));
            sent++;
         end
      end
   endtask

   // result checker: every strobe beat against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_strobe !== 1'b0) begin
         if (pending_conversions.size() == 0) begin
            report_mismatch("result beat with nothing expected");
         end else begin
            want = pending_conversions.pop_front();
            results_checked++;
            if (rsp_out_red !== want.red)
               report_mismatch($sformatf("red got %h want %h", rsp_out_red, want.red));
            if (rsp_out_green !== want.green)
               report_mismatch($sformatf("green got %h want %h", rsp_out_green, want.green));
            if (rsp_out_blue !== want.blue)
               report_mismatch($sformatf("blue got %h want %h", rsp_out_blue, want.blue));
            if (rsp_out_level !== want.level)
               report_mismatch($sformatf("level got %h want %h", rsp_out_level, want.level));
         end
      end
   end

   // test sequence
   initial begin
      shadow_cfg.conv_mode = MODE_BITMAP;
      shadow_cfg.channel_sel = CHAN_RED;
      shadow_cfg.input_max = INPUT_MAX_RST;
      shadow_cfg.gray_max = GRAY_MAX_RST;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset defaults first, before any register write
      send_pixel(16'd0, 16'd255, 16'hFFFF);
      test_bitmap();
      test_grayscale();
      test_channel_modes();
      test_sepia();
      test_spare_modes();
      test_random_traffic(36, 330);
      test_random_traffic(87, 330);
      test_random_traffic(0, 340);
      settle();

      $display("covered %0d pixels under %0d register settings, all modes and selectors,",
         pixels_sent, settings_applied);
      $display("with sparse, bursty and back-to-back input; %0d result beats compared",
         results_checked);
      if (error_count == 0)
         $display("** rgb_pixel_mode_converter_unit: PASSED **");
      else
         $display("** rgb_pixel_mode_converter_unit: FAILED **");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+sv
sv/rpmc_pkg.sv
sv/rpmc_front.sv
sv/rpmc_gray_div.sv
sv/rpmc_color.sv
sv/rgb_pixel_mode_converter_unit.sv
sv/rpmc_checker.sv
test/rgb_pixel_mode_converter_unit_tb.sv
